// ===== rtl/at_response_line_classifier_top_assert.svh =====
// Assertion macros for the response line classifier RTL.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_TOP_ASSERT_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ATRLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ATRLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/atrlc_pkg.sv =====
// Types, constants and match tables for the response line classifier.
package atrlc_pkg;

    localparam int unsigned MAX_CAPACITY_DEF = 4096;
    localparam int unsigned LEN_W            = 13;
    localparam int unsigned CMX_PAT_LEN      = 11;
    localparam int unsigned CAP_RESET        = 64;

    // Configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_KEEP_CR  = 1'b1;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Input function codes
    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INFO     = 3'd2,
        ST_OK       = 3'd3,
        ST_ERROR    = 3'd4,
        ST_CMX      = 3'd5,
        ST_TIMEOUT  = 3'd6,
        ST_OVERFLOW = 3'd7
    } t_status;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [7:0]         data_byte;
        logic [LEN_W-1:0]   line_length;
        logic [LEN_W-1:0]   total_bytes;
        logic               last;
    } t_out_item;

    // Control from the handshake stage to the classifier core
    typedef struct packed {
        logic             step;
        logic             cap_we;
        logic [LEN_W-1:0] cap_data;
    } t_core_ctrl;

    // Expected character of "OK" at a line position
    function automatic logic [7:0] f_ok_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "O";
            4'd1:    ch = "K";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected character of "ERROR" at a line position
    function automatic logic [7:0] f_err_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "E";
            4'd1:    ch = "R";
            4'd2:    ch = "R";
            4'd3:    ch = "O";
            4'd4:    ch = "R";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected character of "+CMx ERROR:" at a line position; x given
    function automatic logic [7:0] f_cmx_char(input logic [3:0] idx,
                                              input logic [7:0] x);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "+";
            4'd1:    ch = "C";
            4'd2:    ch = "M";
            4'd3:    ch = x;
            4'd4:    ch = " ";
            4'd5:    ch = "E";
            4'd6:    ch = "R";
            4'd7:    ch = "R";
            4'd8:    ch = "O";
            4'd9:    ch = "R";
            4'd10:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/atrlc_core.sv =====
// Classifier core: line counters, budget, prefix flags and result decode.
module atrlc_core #(
    parameter int unsigned MAX_CAPACITY = atrlc_pkg::MAX_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  atrlc_pkg::t_core_ctrl       i_ctrl,
    input  atrlc_pkg::t_in_item         i_item,
    input  logic                        i_keep_cr,
    output logic                        o_res_valid,
    output atrlc_pkg::t_out_item        o_res
);

    localparam int unsigned LW = atrlc_pkg::LEN_W;

    // Budget from a capacity value: clamp, then minus one (0 for 0 or 1)
    function automatic logic [LW-1:0] f_base(input logic [LW-1:0] cap);
        logic [LW-1:0] cl;
        cl = (32'(cap) > MAX_CAPACITY) ? LW'(MAX_CAPACITY) : cap;
        return (cl <= LW'(1)) ? '0 : cl - LW'(1);
    endfunction

    logic [LW-1:0] r_capacity;
    logic [LW-1:0] r_budget, n_budget;
    logic [LW-1:0] r_used,   n_used;
    logic [LW-1:0] r_len,    n_len;
    logic          r_ok_m,   n_ok_m;
    logic          r_err_m,  n_err_m;
    logic          r_cme_m,  n_cme_m;
    logic          r_cms_m,  n_cms_m;

    logic [LW-1:0] total;
    logic [LW-1:0] len_inc;
    logic [LW-1:0] budget_sep;
    logic [7:0]    c;
    logic [3:0]    pidx;
    logic          is_ok;
    logic          is_err;
    logic          is_cmx;
    logic          rearm;

    assign total      = r_used + r_len;
    assign len_inc    = r_len + LW'(1);
    assign budget_sep = r_budget - len_inc;
    assign c          = i_item.rx_byte;
    assign pidx       = r_len[3:0];

    assign is_ok  = r_ok_m && (r_len == LW'(2) + LW'(i_keep_cr));
    assign is_err = r_err_m && (r_len == LW'(5) + LW'(i_keep_cr));
    assign is_cmx = (r_len >= LW'(atrlc_pkg::CMX_PAT_LEN)) && (r_cme_m || r_cms_m);

    // Result decode and next line state for the item in the input register
    always_comb begin
        o_res_valid       = 1'b1;
        o_res.status      = atrlc_pkg::ST_DATA;
        o_res.data_byte   = 8'h00;
        o_res.line_length = r_len;
        o_res.total_bytes = total;
        o_res.last        = 1'b0;
        n_budget          = r_budget;
        n_used            = r_used;
        n_len             = r_len;
        n_ok_m            = r_ok_m;
        n_err_m           = r_err_m;
        n_cme_m           = r_cme_m;
        n_cms_m           = r_cms_m;
        if (r_budget == '0) begin
            o_res.status    = atrlc_pkg::ST_OVERFLOW;
            o_res.data_byte = (i_item.func == atrlc_pkg::FUNC_TIMEOUT) ? 8'h00 : c;
            o_res.last      = 1'b1;
        end else if (i_item.func == atrlc_pkg::FUNC_TIMEOUT) begin
            o_res.status = atrlc_pkg::ST_TIMEOUT;
            o_res.last   = 1'b1;
        end else if (c == atrlc_pkg::CHAR_CR && !i_keep_cr) begin
            o_res_valid = 1'b0;
        end else if (c != atrlc_pkg::CHAR_LF) begin
            // line byte: data, or overflow if it fills the budget
            o_res.data_byte   = c;
            o_res.line_length = len_inc;
            o_res.total_bytes = total + LW'(1);
            n_len             = len_inc;
            if ({1'b0, len_inc} >= {1'b0, r_budget}) begin
                o_res.status = atrlc_pkg::ST_OVERFLOW;
                o_res.last   = 1'b1;
            end else begin
                if (r_len < LW'(2) && c != atrlc_pkg::f_ok_char(pidx))
                    n_ok_m = 1'b0;
                if (r_len < LW'(5) && c != atrlc_pkg::f_err_char(pidx))
                    n_err_m = 1'b0;
                if (r_len < LW'(atrlc_pkg::CMX_PAT_LEN)
                    && c != atrlc_pkg::f_cmx_char(pidx, "E"))
                    n_cme_m = 1'b0;
                if (r_len < LW'(atrlc_pkg::CMX_PAT_LEN)
                    && c != atrlc_pkg::f_cmx_char(pidx, "S"))
                    n_cms_m = 1'b0;
            end
        end else if (is_ok) begin
            o_res.status = atrlc_pkg::ST_OK;
            o_res.last   = 1'b1;
        end else if (is_err) begin
            o_res.status = atrlc_pkg::ST_ERROR;
            o_res.last   = 1'b1;
        end else if (is_cmx) begin
            o_res.status = atrlc_pkg::ST_CMX;
            o_res.last   = 1'b1;
        end else begin
            // line separator is charged to the budget
            o_res.total_bytes = total + LW'(1);
            if (budget_sep == '0) begin
                o_res.status = atrlc_pkg::ST_OVERFLOW;
                o_res.last   = 1'b1;
            end else begin
                o_res.status = (r_len == '0) ? atrlc_pkg::ST_EMPTY : atrlc_pkg::ST_INFO;
                n_budget     = budget_sep;
                n_used       = r_used + len_inc;
                n_len        = '0;
                n_ok_m       = 1'b1;
                n_err_m      = 1'b1;
                n_cme_m      = 1'b1;
                n_cms_m      = 1'b1;
            end
        end
    end

    assign rearm = i_ctrl.step && o_res_valid && o_res.last;

    // Capacity register; a write re-arms with the new value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LW'(atrlc_pkg::CAP_RESET);
        end else if (i_ctrl.cap_we) begin
            r_capacity <= i_ctrl.cap_data;
        end
    end

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= f_base(LW'(atrlc_pkg::CAP_RESET));
            r_used   <= '0;
            r_len    <= '0;
            r_ok_m   <= 1'b1;
            r_err_m  <= 1'b1;
            r_cme_m  <= 1'b1;
            r_cms_m  <= 1'b1;
        end else if (i_ctrl.cap_we || rearm) begin
            r_budget <= i_ctrl.cap_we ? f_base(i_ctrl.cap_data) : f_base(r_capacity);
            r_used   <= '0;
            r_len    <= '0;
            r_ok_m   <= 1'b1;
            r_err_m  <= 1'b1;
            r_cme_m  <= 1'b1;
            r_cms_m  <= 1'b1;
        end else if (i_ctrl.step) begin
            r_budget <= n_budget;
            r_used   <= n_used;
            r_len    <= n_len;
            r_ok_m   <= n_ok_m;
            r_err_m  <= n_err_m;
            r_cme_m  <= n_cme_m;
            r_cms_m  <= n_cms_m;
        end
    end

endmodule

// ===== rtl/at_response_line_classifier_top.sv =====
// Top level of the AT response line classifier: handshake stages and config.
// One item (a received byte or a timeout event) is taken per clock cycle, back
// to back, unless the input stalls as below: an input register feeds the
// classifier core, whose line counters, response budget and four prefix flags
// are updated in that same cycle, and the result lands in an output register. A
// dropped CR gives no result item. Every final code, timeout or overflow re-arms
// the block, as does a write of response_capacity (register 0), which takes
// effect at once; there is no clearing pass after reset. keep_carriage_return is
// register 1. A result that waits at the output stalls the input only when both
// registers are full.
module at_response_line_classifier_top #(
    parameter int unsigned MAX_CAPACITY = atrlc_pkg::MAX_CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  atrlc_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output atrlc_pkg::t_out_item                o_out_item,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [atrlc_pkg::LEN_W-1:0]         i_cfg_wdata
);

    logic                  r_in_valid;
    atrlc_pkg::t_in_item   r_in_item;
    logic                  r_out_valid;
    atrlc_pkg::t_out_item  r_out_item;
    logic                  r_keep_cr;
    logic                  out_free;
    logic                  advance;
    logic                  res_valid;
    atrlc_pkg::t_out_item  res;
    atrlc_pkg::t_core_ctrl ctrl;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign ctrl.step     = advance;
    assign ctrl.cap_we   = i_cfg_we && (i_cfg_index == atrlc_pkg::REG_CAPACITY);
    assign ctrl.cap_data = i_cfg_wdata;

    // keep_carriage_return register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_cr <= 1'b0;
        end else if (i_cfg_we && i_cfg_index == atrlc_pkg::REG_KEEP_CR) begin
            r_keep_cr <= i_cfg_wdata[0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    atrlc_core #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_item      (r_in_item),
        .i_keep_cr   (r_keep_cr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    `include "at_response_line_classifier_top_assert.svh"

    `ATRLC_ASSERT_IMP(a_empty_stage_ready, !r_in_valid, o_in_ready, "input stage empty but not ready")
    `ATRLC_ASSERT_IMP(a_data_has_length, o_out_valid && o_out_item.status == atrlc_pkg::ST_DATA, o_out_item.line_length != '0, "data item with zero line length")
    `ATRLC_ASSERT_IMP(a_total_covers_line, o_out_valid, o_out_item.total_bytes >= o_out_item.line_length, "total below line length")
    `ATRLC_ASSERT_NXT(a_nonfinal_status, advance && res_valid && !res.last, o_out_item.status == atrlc_pkg::ST_DATA || o_out_item.status == atrlc_pkg::ST_EMPTY || o_out_item.status == atrlc_pkg::ST_INFO, "non-final item with final status")

endmodule
